// ===== src/first_fit_block_allocator_defines.svh =====
// Assertion macros for the first-fit block allocator checker.
// Depends on nothing; included by files that assert.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int DEF_MAX_BLOCKS = 16;
  localparam int DEF_POOL_BYTES = 65536;

  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 17;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Word travelling down the cell chain, one cell per cycle.
  typedef struct packed {
    logic              valid;
    op_t               func;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic [ADDR_W-1:0] hit_start;
    logic [SIZE_W-1:0] hit_len;
  } probe_t;

  // Broadcast update issued when a probe leaves the last cell.
  typedef struct packed {
    logic              append;
    logic              clear_all;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] length;
  } upd_t;

endpackage

`default_nettype wire

// ===== src/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: launch stage, cell chain, finish stage.
// Depends on ffba_pkg and ffba_cell.
`timescale 1ns / 1ps
`default_nettype none

// First-fit block allocator with a bump pointer.
//
// Command port: a word (func, req_size, free_addr) is taken at a rising edge
// where start is high and busy is low. busy rises at the next cycle and stays
// high while the word walks the chain of MAX_BLOCKS cells, one cell a cycle.
// Each cell holds one table entry; the first free entry that covers an
// allocate claims it, and every entry at a freed offset drops its mark.
// When the word leaves the last cell the finish stage decides the append,
// broadcasts the table update and registers the result.
//
// Result port: done is high for exactly one cycle, registered as the word
// leaves the last cell, with status, block_addr and block_len. busy is
// low in that same cycle, so a new word can be taken at its closing edge:
// one word at a time, the pace being set by the length of the cell chain.
// The receiver cannot stall; it must take each result as it comes.
//
// Reset (rst, synchronous): empties the table, zeroes the entry count and
// the bump top, and drops any word in flight. No clearing pass is needed.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int POOL_BYTES = DEF_POOL_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [FUNC_W-1:0]   func,
  input  wire logic [SIZE_W-1:0]   req_size,
  input  wire logic [ADDR_W-1:0]   free_addr,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [ADDR_W-1:0]        block_addr,
  output logic [SIZE_W-1:0]        block_len
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int HW = $clog2(POOL_BYTES + 1);
  localparam int TW = ((HW > SIZE_W) ? HW : SIZE_W) + 1;

  logic [CW-1:0] count;
  logic [HW-1:0] heap_top;

  probe_t chain [MAX_BLOCKS+1];
  probe_t fin;
  upd_t   upd;

  logic                accept;
  logic                room;
  logic [STATUS_W-1:0] status_next;
  logic [ADDR_W-1:0]   addr_next;
  logic [SIZE_W-1:0]   len_next;
  logic [MAX_BLOCKS-1:0] upd_sel;

  assign accept = start && !busy;
  assign fin    = chain[MAX_BLOCKS];

  // Launch stage: capture the command word into the head of the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= accept;
    end
    if (accept) begin
      chain[0].func      <= op_t'(func);
      chain[0].size      <= req_size;
      chain[0].addr      <= free_addr;
      chain[0].found     <= 1'b0;
      chain[0].hit_start <= '0;
      chain[0].hit_len   <= '0;
    end
  end

  // Cell chain: one table entry per cell.
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    assign upd_sel[i] = (count[IW-1:0] == IW'(i));

    ffba_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1]),
      .upd       (upd),
      .upd_sel   (upd_sel[i])
    );
  end

  // Append needs a free table slot and enough pool left above the top.
  assign room = (count < CW'(MAX_BLOCKS)) && (heap_top < HW'(POOL_BYTES)) &&
                (TW'(fin.size) <= (TW'(POOL_BYTES) - TW'(heap_top)));

  // Finish stage: pick the result and the table update.
  always_comb begin
    status_next   = ST_OK;
    addr_next     = '0;
    len_next      = '0;
    upd.append    = 1'b0;
    upd.clear_all = 1'b0;
    upd.start     = ADDR_W'(heap_top);
    upd.length    = fin.size;
    unique case (fin.func)
      OP_ALLOC: begin
        if (fin.found) begin
          addr_next = fin.hit_start;
          len_next  = fin.hit_len;
        end else if (room) begin
          upd.append = fin.valid;
          addr_next  = ADDR_W'(heap_top);
          len_next   = fin.size;
        end else begin
          status_next = ST_NO_ROOM;
        end
      end
      OP_FREE: begin
        addr_next = fin.addr;
        if (fin.found) begin
          len_next = fin.hit_len;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        upd.clear_all = fin.valid;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control: busy, strobe, entry count and bump top.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      count    <= '0;
      heap_top <= '0;
    end else begin
      done <= fin.valid;
      if (accept) begin
        busy <= 1'b1;
      end else if (fin.valid) begin
        busy <= 1'b0;
      end
      if (upd.clear_all) begin
        count    <= '0;
        heap_top <= '0;
      end else if (upd.append) begin
        count    <= count + CW'(1);
        heap_top <= heap_top + HW'(fin.size);
      end
    end
  end

  // Result word: hold until the next finish.
  always_ff @(posedge clk) begin
    if (fin.valid) begin
      status     <= status_next;
      block_addr <= addr_next;
      block_len  <= len_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/ffba_cell.sv =====
// One table entry of the first-fit block allocator and its chain stage.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffba_cell
  import ffba_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire probe_t probe_in,
  output probe_t      probe_out,
  input  wire upd_t   upd,
  input  wire logic   upd_sel
);

  logic              live;
  logic              in_use;
  logic [ADDR_W-1:0] start;
  logic [SIZE_W-1:0] length;

  logic   alloc_hit;
  logic   free_hit;
  probe_t probe_next;

  assign alloc_hit = probe_in.valid && live && (probe_in.func == OP_ALLOC) &&
                     !in_use && !probe_in.found && (length >= probe_in.size);
  assign free_hit  = probe_in.valid && live && (probe_in.func == OP_FREE) &&
                     (start == probe_in.addr);

  always_comb begin
    probe_next = probe_in;
    if (alloc_hit) begin
      probe_next.found     = 1'b1;
      probe_next.hit_start = start;
      probe_next.hit_len   = length;
    end else if (free_hit && !probe_in.found) begin
      probe_next.found   = 1'b1;
      probe_next.hit_len = length;
    end
  end

  // Hand the word to the next cell; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_next.valid;
    end
    probe_out.func      <= probe_next.func;
    probe_out.size      <= probe_next.size;
    probe_out.addr      <= probe_next.addr;
    probe_out.found     <= probe_next.found;
    probe_out.hit_start <= probe_next.hit_start;
    probe_out.hit_len   <= probe_next.hit_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live   <= 1'b0;
      in_use <= 1'b0;
    end else if (upd.clear_all) begin
      live   <= 1'b0;
      in_use <= 1'b0;
    end else if (upd.append && upd_sel) begin
      live   <= 1'b1;
      in_use <= 1'b1;
    end else if (alloc_hit) begin
      in_use <= 1'b1;
    end else if (free_hit) begin
      in_use <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.append && upd_sel) begin
      start  <= upd.start;
      length <= upd.length;
    end
  end

endmodule

`default_nettype wire

// ===== src/ffba_checker.sv =====
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_block_allocator_defines.svh"

module ffba_checker
  import ffba_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [ADDR_W-1:0]   block_addr,
  input wire logic [SIZE_W-1:0]   block_len
);

  `FFBA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done, "busy did not rise")
  `FFBA_ASSERT_NOW(a_busy_done, clk, rst, $fell(busy), done, "busy dropped without a result")
  `FFBA_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result shown while still busy")
  `FFBA_ASSERT_NOW(a_no_room, clk, rst, done && (status == ST_NO_ROOM), (block_addr == '0) && (block_len == '0), "no-room result carries a block")
  `FFBA_ASSERT_NOW(a_not_found, clk, rst, done && (status == ST_NOT_FOUND), block_len == '0, "not-found result carries a length")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

`default_nettype wire
